FILE: rtl/bounded_set_table_top_defines.svh
// assertion macros for the bounded set table
`ifndef BOUNDED_SET_TABLE_TOP_DEFINES_SVH
`define BOUNDED_SET_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define BST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bst assertion failed");

// next-cycle implication
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bst assertion failed");

`endif

FILE: rtl/bst_pkg.sv
// shared types and codes for the bounded set table
package bst_pkg;

  localparam int VAL_W = 32;
  localparam int REQ_W = 2;
  localparam int CAP_W = 5;
  localparam int POS_W = 4;
  localparam int CNT_OUT_W = 5;

  localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REM  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOK = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic                 dropped;
    logic [CNT_OUT_W-1:0] count;
    logic [POS_W-1:0]     position;
    logic                 found;
  } bst_res_t;

endpackage

FILE: rtl/bst_mem.sv
// entry store: one write port, one registered read port
module bst_mem
  import bst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bst_ctrl.sv
// request sequencer: scans the store, then answers a look-up, adds or swap-removes one entry
module bst_ctrl
  import bst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REQ_W-1:0] in_req,
  input  logic [VAL_W-1:0] in_val,
  input  logic [CAP_W-1:0] capacity,
  input  logic             out_free,
  output logic             res_push,
  output bst_res_t         res,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output logic [VAL_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  logic [VAL_W-1:0] mem_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_ACT  = 4'b0100,
    ST_MOVE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmpv_r, cmpv_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             hit_r, hit_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] cap_eff;
  logic             issue;
  logic             hit_now;
  logic             has_room;
  logic [CNT_W-1:0] last_idx;

  assign cap_eff  = ({27'd0, capacity} > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity);
  assign issue    = scan_r < cnt_r;
  assign hit_now  = cmpv_r && (mem_rdata == val_r);
  assign has_room = cnt_r < cap_eff;
  assign last_idx = cnt_r - 1'b1;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    scan_nxt    = scan_r;
    cmp_idx_nxt = cmp_idx_r;
    cmpv_nxt    = cmpv_r;
    slot_nxt    = slot_r;
    hit_nxt     = hit_r;
    req_nxt     = req_r;
    val_nxt     = val_r;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r[IDX_W-1:0];
    mem_wdata   = val_r;
    mem_re      = 1'b0;
    mem_raddr   = scan_r[IDX_W-1:0];
    res_push    = 1'b0;
    res.found    = hit_r;
    res.position = POS_W'(slot_r);
    res.count    = CNT_OUT_W'(cnt_r);
    res.dropped  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          val_nxt   = in_val;
          scan_nxt  = '0;
          cmpv_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          hit_nxt   = 1'b1;
          slot_nxt  = cmp_idx_r;
          state_nxt = ST_ACT;
        end else if (!issue) begin
          hit_nxt   = 1'b0;
          slot_nxt  = '0;
          state_nxt = ST_ACT;
        end else begin
          mem_re      = 1'b1;
          cmp_idx_nxt = scan_r[IDX_W-1:0];
          cmpv_nxt    = 1'b1;
          scan_nxt    = scan_r + 1'b1;
        end
      end
      ST_ACT: begin
        case (req_r)
          REQ_ADD: begin
            res.dropped = !hit_r && !has_room;
            if (!hit_r && has_room) begin
              res.count = CNT_OUT_W'(cnt_r + 1'b1);
            end
            if (out_free) begin
              res_push  = 1'b1;
              state_nxt = ST_IDLE;
              if (!hit_r && has_room) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
          REQ_REM: begin
            if (hit_r) begin
              mem_re    = 1'b1;
              mem_raddr = last_idx[IDX_W-1:0];
              state_nxt = ST_MOVE;
            end else if (out_free) begin
              res_push  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              res_push  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_MOVE: begin
        res.count = CNT_OUT_W'(last_idx);
        mem_waddr = slot_r;
        mem_wdata = mem_rdata;
        if (out_free) begin
          mem_we    = 1'b1;
          cnt_nxt   = last_idx;
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      cmpv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cmpv_r  <= cmpv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    hit_r     <= hit_nxt;
    req_r     <= req_nxt;
    val_r     <= val_nxt;
  end

endmodule

FILE: rtl/bounded_set_table_top.sv
// bounded set table top: array-backed set with swap remove
// steps: accept (idle), a scan of the stored entries (memory read port), an action step,
//   plus a move step for a remove that hits; result then sits in the output register
// one request at a time: none is taken before the last result is pushed; a full output stalls it
// reset: rst_n synchronous active low; count cleared, capacity set to 16, store undefined
module bounded_set_table_top
  import bst_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found[0], position[4:1], count[9:5], dropped[10], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // capacity[4:0]
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CAP_W-1:0] cap_r;
  logic             out_vld_r, out_vld_nxt;
  bst_res_t         out_res_r;
  bst_res_t         res;
  logic             res_push;
  logic             out_free;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  assign cfg_ready   = 1'b1;
  assign out_free    = !out_vld_r || out_tready;
  assign out_vld_nxt = res_push || (out_vld_r && !out_tready);
  assign out_tvalid  = out_vld_r;
  assign out_tdata   = {5'd0, out_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  bst_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .in_val    (in_tdata),
    .capacity  (cap_r),
    .out_free  (out_free),
    .res_push  (res_push),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bst_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`include "bounded_set_table_top_defines.svh"

  `BST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BST_ASSERT_IMPL(a_push_only_when_free, clk, rst_n, res_push, out_free)
  `BST_ASSERT_IMPL(a_drop_not_found, clk, rst_n, out_vld_r && out_res_r.dropped,
                   !out_res_r.found && (out_res_r.position == '0))
  `BST_ASSERT_IMPL(a_count_bound, clk, rst_n, out_vld_r, {27'd0, out_res_r.count} <= DEPTH)

endmodule

FILE: sim/bounded_set_table_top_tb.sv
// testbench for the bounded set table: directed and random add, remove and look-up traffic
`timescale 1ns / 1ps

module bounded_set_table_top_tb;
  import bst_pkg::*;

  localparam int DEPTH = 16;
  localparam int POOL_SIZE = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data = '0;

  // predicted contents of the table
  logic [VAL_W-1:0]  tb_slots [DEPTH];
  int                tb_count = 0;
  logic [CAP_W-1:0]  tb_capacity = CAP_RESET;

  bst_res_t          pending_results [$];
  logic [VAL_W-1:0]  value_pool [POOL_SIZE];
  int                mismatch_count = 0;
  int                tx_burst_left = 0;
  int                rx_hold = 0;
  int unsigned       rx_cycle = 0;
  int unsigned       cycle_count = 0;

  bounded_set_table_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic bst_res_t apply_set_request(input logic [REQ_W-1:0] kind,
                                                 input logic [VAL_W-1:0] val);
    bst_res_t r;
    int hit_slot;
    int limit;
    r = '0;
    hit_slot = -1;
    limit = (tb_capacity > DEPTH) ? DEPTH : int'(tb_capacity);
    for (int i = 0; i < tb_count; i++) begin
      if (hit_slot < 0 && tb_slots[i] == val) hit_slot = i;
    end
    r.found = (hit_slot >= 0);
    r.position = (hit_slot >= 0) ? hit_slot[POS_W-1:0] : '0;
    case (kind)
      REQ_ADD: begin
        if (hit_slot < 0) begin
          if (tb_count < limit) begin
            tb_slots[tb_count] = val;
            tb_count++;
          end else begin
            r.dropped = 1'b1;
          end
        end
      end
      REQ_REM: begin
        if (hit_slot >= 0) begin
          tb_count--;
          tb_slots[hit_slot] = tb_slots[tb_count];
        end
      end
      default: begin
      end
    endcase
    r.count = tb_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] val);
    int gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_set_request(kind, val));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    tx_burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tb_capacity = cap;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_req(REQ_LOOK, 32'h0000_0000);
    send_req(REQ_REM, 32'h7fff_ffff);
    send_req(REQ_SPARE, 32'h8000_0000);
  endtask

  task automatic test_add_and_swap_remove();
    send_req(REQ_ADD, 32'h8000_0000);
    send_req(REQ_ADD, 32'h7fff_ffff);
    send_req(REQ_ADD, 32'hffff_ffff);
    send_req(REQ_ADD, 32'h0000_0000);
    send_req(REQ_ADD, 32'h0000_0000);
    send_req(REQ_LOOK, 32'hffff_ffff);
    // freed first slot takes the last entry
    send_req(REQ_REM, 32'h8000_0000);
    send_req(REQ_LOOK, 32'h0000_0000);
    send_req(REQ_SPARE, 32'h7fff_ffff);
  endtask

  task automatic test_capacity_limits();
    // capacity below the live count keeps the entries
    write_capacity(5'd2);
    send_req(REQ_ADD, 32'h1234_5678);
    send_req(REQ_REM, 32'h0000_0000);
    send_req(REQ_ADD, 32'h1234_5678);
    send_req(REQ_REM, 32'h7fff_ffff);
    send_req(REQ_ADD, 32'h5555_aaaa);
    write_capacity(5'd0);
    send_req(REQ_ADD, 32'haaaa_5555);
    send_req(REQ_ADD, 32'h5555_aaaa);
    send_req(REQ_REM, 32'h1234_5678);
    write_capacity(5'd31);
    send_req(REQ_ADD, 32'hdead_beef);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [9] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd17, 5'd3, 5'd16, 5'd0};
    logic [REQ_W-1:0] kind;
    logic [VAL_W-1:0] val;
    int pick;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hffff_ffff;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7fff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (int p = 0; p < 9; p++) begin
      if (p == 8) caps[p] = CAP_W'($urandom_range(0, 31));
      write_capacity(caps[p]);
      for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      for (int n = 0; n < 180; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) kind = REQ_ADD;
        else if (pick < 70) kind = REQ_REM;
        else if (pick < 95) kind = REQ_LOOK;
        else kind = REQ_SPARE;
        if ($urandom_range(0, 99) < 85) val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else val = $urandom;
        send_req(kind, val);
      end
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // result word check against the oldest prediction
  always @(posedge clk) begin
    bst_res_t got;
    bst_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = bst_res_t'(out_tdata[10:0]);
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", int'(want.found), int'(got.found));
        check_field("position", int'(want.position), int'(got.position));
        check_field("count", int'(want.count), int'(got.count));
        check_field("dropped", int'(want.dropped), int'(got.dropped));
        check_field("padding", 0, int'(out_tdata[15:11]));
      end
    end
  end

  // receiver stalls at random, with free-flowing stretches while bit 9 of rx_cycle is set
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[9]) begin
      out_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(1, 20);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_add_and_swap_remove();
    test_capacity_limits();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bst_pkg.sv
rtl/bst_mem.sv
rtl/bst_ctrl.sv
rtl/bounded_set_table_top.sv
sim/bounded_set_table_top_tb.sv
